// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF    = 65536;
  localparam int unsigned HEADER_BYTES_DEF  = 24;
  localparam int unsigned GRANULE_BYTES_DEF = 8;

  localparam int unsigned MIN_BLOCK   = 32;
  localparam int unsigned ROUND_TO    = 16;
  localparam int unsigned RESET_HEAP  = 65536;

  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned CFG_W       = 17;
  localparam int unsigned STATUS_W    = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 2'd0,
    ST_ALLOC_FAIL   = 2'd1,
    ST_FREE_IGNORED = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator with coalescing over a heap of block headers.
// ----------------------------------------------------------------------------
// Timing: data dependent; allocate reads each free-list node visited (A_RD, A_CHK),
//   free walks blocks from offset 0 (W_RD, W_CHK) plus free-list walks.
// Throughput: one transaction at a time; busy stays high until done_o pulses.
// Results pulse for one cycle on done_o and cannot be stalled.
// Reset: one cycle after rst_ni releases, header 0 is formatted; busy meanwhile.
`default_nettype none

module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          mode_i,
  input  wire logic [ffha_pkg::FIELD_W-1:0]  request_size_i,
  input  wire logic [ffha_pkg::FIELD_W-1:0]  block_address_i,
  output      logic                          done_o,
  output      logic [ffha_pkg::FIELD_W-1:0]  alloc_address_o,
  output      logic [ffha_pkg::STATUS_W-1:0] status_o,
  input  wire logic                          heap_size_we_i,
  input  wire logic [ffha_pkg::CFG_W-1:0]    heap_size_i
);

  localparam int unsigned DEPTH  = HEAP_BYTES / GRANULE_BYTES;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned OFF_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned WORD_W = OFF_W + SLOT_W + 2;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  ffha_ctrl #(
    .HEAP_BYTES    (HEAP_BYTES),
    .HEADER_BYTES  (HEADER_BYTES),
    .GRANULE_BYTES (GRANULE_BYTES),
    .DEPTH         (DEPTH),
    .SLOT_W        (SLOT_W),
    .OFF_W         (OFF_W),
    .WORD_W        (WORD_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .done_o          (done_o),
    .alloc_address_o (alloc_address_o),
    .status_o        (status_o),
    .heap_size_we_i  (heap_size_we_i),
    .heap_size_i     (heap_size_i),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  ffha_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_mem.sv =====
// ----------------------------------------------------------------------------
// ffha_mem
// Block header store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer that walks the tiling and the free list through the header store.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl #(
  parameter int unsigned HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF,
  parameter int unsigned DEPTH         = HEAP_BYTES / GRANULE_BYTES,
  parameter int unsigned SLOT_W        = $clog2(DEPTH),
  parameter int unsigned OFF_W         = $clog2(HEAP_BYTES + 1),
  parameter int unsigned WORD_W        = OFF_W + SLOT_W + 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic                          mode_i,
  input  wire logic [ffha_pkg::FIELD_W-1:0]  request_size_i,
  input  wire logic [ffha_pkg::FIELD_W-1:0]  block_address_i,
  output      logic                          done_o,
  output      logic [ffha_pkg::FIELD_W-1:0]  alloc_address_o,
  output      logic [ffha_pkg::STATUS_W-1:0] status_o,
  input  wire logic                          heap_size_we_i,
  input  wire logic [ffha_pkg::CFG_W-1:0]    heap_size_i,
  output      logic                          mem_we_o,
  output      logic [SLOT_W-1:0]             mem_waddr_o,
  output      logic [WORD_W-1:0]             mem_wdata_o,
  output      logic [SLOT_W-1:0]             mem_raddr_o,
  input  wire logic [WORD_W-1:0]             mem_rdata_i
);

  import ffha_pkg::*;

  localparam int unsigned GSH   = $clog2(GRANULE_BYTES);
  localparam int unsigned CW    = ((OFF_W > 18) ? OFF_W : 18) + 1;
  localparam int unsigned XW    = (OFF_W > 16) ? OFF_W : 16;
  localparam int unsigned RST_H = (RESET_HEAP > HEAP_BYTES) ? HEAP_BYTES : RESET_HEAP;

  typedef struct packed {
    logic [OFF_W-1:0]  size;
    logic [SLOT_W-1:0] nxt;
    logic              ok;
    logic              free;
  } hdr_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    A_RD, A_CHK, A_UNL, A_WREST, A_WPREV, A_WCUR,
    W_RD, W_CHK,
    F_FWD, F_NX_RD, F_NX_CHK, F_WBLK, F_MERGE, F_FINAL,
    U_START, U_RD, U_CHK
  } state_e;

  typedef enum logic { RET_FWD, RET_BACK } ret_e;

  state_e            state_q;
  ret_e              ret_q;
  logic [OFF_W-1:0]  heap_q;
  logic [SLOT_W-1:0] fh_q;
  logic              fhv_q;
  logic [OFF_W-1:0]  cur_q, prev_q, blk_q, p_q, last_q, tgt_q;
  logic              have_prev_q, have_last_q, walk_chk_q, split_q;
  logic [CW-1:0]     need_q;
  hdr_t              hdr_q, prev_hdr_q, bhdr_q, last_hdr_q, u_hdr_q;
  logic [SLOT_W-1:0] u_slot_q, up_q;
  logic              done_q;
  logic [FIELD_W-1:0] addr_q;
  logic [STATUS_W-1:0] st_q;

  hdr_t              rd;
  logic              usable;
  logic [OFF_W-1:0]  cfg_heap;
  logic [OFF_W-1:0]  rest;
  logic [OFF_W:0]    w_next;
  logic [OFF_W:0]    f_next;
  logic [16:0]       rnd;
  logic [CW-1:0]     need_raw;
  logic [XW-1:0]     blk_x;
  hdr_t              wr;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
    return off[GSH +: SLOT_W];
  endfunction

  function automatic logic [OFF_W-1:0] off_of(input logic [SLOT_W-1:0] s);
    return OFF_W'(s) << GSH;
  endfunction

  assign rd       = hdr_t'(mem_rdata_i);
  assign usable   = heap_q >= OFF_W'(HEADER_BYTES + 16);
  assign cfg_heap = (32'(heap_size_i) > 32'(HEAP_BYTES)) ? OFF_W'(HEAP_BYTES)
                                                          : OFF_W'(heap_size_i);
  assign rest     = cur_q + OFF_W'(need_q);
  assign w_next   = {1'b0, p_q} + {1'b0, rd.size};
  assign f_next   = {1'b0, blk_q} + {1'b0, bhdr_q.size};
  assign rnd      = ({1'b0, request_size_i} + 17'(ROUND_TO - 1)) & ~17'(ROUND_TO - 1);
  assign need_raw = CW'(rnd) + CW'(HEADER_BYTES);
  assign blk_x    = XW'(block_address_i) - XW'(HEADER_BYTES);

  assign busy            = state_q != S_IDLE;
  assign done_o          = done_q;
  assign alloc_address_o = addr_q;
  assign status_o        = st_q;

  // memory ports
  always_comb begin
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    wr          = '0;
    case (state_q)
      A_RD:    mem_raddr_o = slot_of(cur_q);
      W_RD:    mem_raddr_o = slot_of(p_q);
      F_NX_RD: mem_raddr_o = slot_of(cur_q);
      U_RD:    mem_raddr_o = up_q;
      default: mem_raddr_o = '0;
    endcase
    if (heap_size_we_i) begin
      mem_we_o = cfg_heap >= OFF_W'(HEADER_BYTES + 16);
      wr       = '{size: cfg_heap, nxt: '0, ok: 1'b0, free: 1'b1};
    end else begin
      case (state_q)
        S_INIT: begin
          mem_we_o = usable;
          wr       = '{size: heap_q, nxt: '0, ok: 1'b0, free: 1'b1};
        end
        A_UNL: begin
          mem_we_o    = have_prev_q;
          mem_waddr_o = slot_of(prev_q);
          wr = '{size: prev_hdr_q.size, nxt: hdr_q.nxt, ok: hdr_q.ok,
                 free: prev_hdr_q.free};
        end
        A_WREST: begin
          mem_we_o    = 1'b1;
          mem_waddr_o = slot_of(rest);
          wr = '{size: hdr_q.size - OFF_W'(need_q), nxt: hdr_q.nxt, ok: hdr_q.ok,
                 free: 1'b1};
        end
        A_WPREV: begin
          mem_we_o    = 1'b1;
          mem_waddr_o = slot_of(prev_q);
          wr = '{size: prev_hdr_q.size, nxt: slot_of(rest), ok: 1'b1,
                 free: prev_hdr_q.free};
        end
        A_WCUR: begin
          mem_we_o    = 1'b1;
          mem_waddr_o = slot_of(cur_q);
          wr = '{size: split_q ? OFF_W'(need_q) : hdr_q.size, nxt: '0, ok: 1'b0,
                 free: 1'b0};
        end
        F_WBLK: begin
          mem_we_o    = 1'b1;
          mem_waddr_o = slot_of(blk_q);
          wr          = bhdr_q;
        end
        F_FINAL: begin
          mem_we_o    = 1'b1;
          mem_waddr_o = slot_of(blk_q);
          wr = '{size: bhdr_q.size, nxt: fh_q, ok: fhv_q, free: 1'b1};
        end
        U_CHK: begin
          mem_we_o    = rd.ok && (rd.nxt == u_slot_q);
          mem_waddr_o = up_q;
          wr = '{size: rd.size, nxt: u_hdr_q.nxt, ok: u_hdr_q.ok, free: rd.free};
        end
        default: mem_we_o = 1'b0;
      endcase
    end
    mem_wdata_o = WORD_W'(wr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ret_q       <= RET_FWD;
      heap_q      <= OFF_W'(RST_H);
      fh_q        <= '0;
      fhv_q       <= (RST_H >= HEADER_BYTES + 16);
      done_q      <= 1'b0;
      have_prev_q <= 1'b0;
      have_last_q <= 1'b0;
      walk_chk_q  <= 1'b0;
      split_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (heap_size_we_i) begin
        heap_q <= cfg_heap;
        fh_q   <= '0;
        fhv_q  <= cfg_heap >= OFF_W'(HEADER_BYTES + 16);
      end
      case (state_q)
        S_INIT: state_q <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            addr_q <= '0;
            if (mode_i == MODE_ALLOC) begin
              if (request_size_i == '0 || !usable || !fhv_q) begin
                st_q    <= ST_ALLOC_FAIL;
                done_q  <= 1'b1;
              end else begin
                need_q      <= (need_raw < CW'(MIN_BLOCK)) ? CW'(MIN_BLOCK) : need_raw;
                cur_q       <= off_of(fh_q);
                have_prev_q <= 1'b0;
                state_q     <= A_RD;
              end
            end else begin
              if (!usable || block_address_i < FIELD_W'(HEADER_BYTES) ||
                  blk_x >= XW'(heap_q)) begin
                st_q   <= ST_FREE_IGNORED;
                done_q <= 1'b1;
              end else begin
                blk_q       <= OFF_W'(blk_x);
                tgt_q       <= OFF_W'(blk_x);
                p_q         <= '0;
                have_last_q <= 1'b0;
                walk_chk_q  <= 1'b1;
                state_q     <= W_RD;
              end
            end
          end
        end
        A_RD: state_q <= A_CHK;
        A_CHK: begin
          if (rd.free && CW'(rd.size) >= need_q) begin
            hdr_q   <= rd;
            split_q <= CW'(rd.size) >= need_q + CW'(MIN_BLOCK);
            state_q <= (CW'(rd.size) >= need_q + CW'(MIN_BLOCK)) ? A_WREST : A_UNL;
          end else if (!rd.ok) begin
            st_q    <= ST_ALLOC_FAIL;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            prev_q      <= cur_q;
            prev_hdr_q  <= rd;
            have_prev_q <= 1'b1;
            cur_q       <= off_of(rd.nxt);
            state_q     <= A_RD;
          end
        end
        A_UNL: begin
          if (!have_prev_q) begin
            fh_q  <= hdr_q.nxt;
            fhv_q <= hdr_q.ok;
          end
          state_q <= A_WCUR;
        end
        A_WREST: begin
          if (have_prev_q) begin
            state_q <= A_WPREV;
          end else begin
            fh_q    <= slot_of(rest);
            fhv_q   <= 1'b1;
            state_q <= A_WCUR;
          end
        end
        A_WPREV: state_q <= A_WCUR;
        A_WCUR: begin
          addr_q  <= FIELD_W'(XW'(cur_q) + XW'(HEADER_BYTES));
          st_q    <= ST_DONE;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        W_RD: state_q <= W_CHK;
        W_CHK: begin
          if (p_q == tgt_q) begin
            if (walk_chk_q) begin
              if (rd.free) begin
                st_q    <= ST_FREE_IGNORED;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                bhdr_q  <= '{size: rd.size, nxt: rd.nxt, ok: rd.ok, free: 1'b1};
                state_q <= F_FWD;
              end
            end else if (have_last_q && last_hdr_q.free) begin
              u_slot_q <= slot_of(last_q);
              u_hdr_q  <= last_hdr_q;
              ret_q    <= RET_BACK;
              state_q  <= U_START;
            end else begin
              state_q <= F_FINAL;
            end
          end else if (p_q > tgt_q || rd.size == '0 || w_next >= {1'b0, heap_q}) begin
            if (walk_chk_q) begin
              st_q    <= ST_FREE_IGNORED;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= F_FINAL;
            end
          end else begin
            last_q      <= p_q;
            last_hdr_q  <= rd;
            have_last_q <= 1'b1;
            p_q         <= OFF_W'(w_next);
            state_q     <= W_RD;
          end
        end
        F_FWD: begin
          if (f_next >= {1'b0, heap_q}) begin
            state_q <= F_WBLK;
          end else begin
            cur_q   <= OFF_W'(f_next);
            state_q <= F_NX_RD;
          end
        end
        F_NX_RD: state_q <= F_NX_CHK;
        F_NX_CHK: begin
          if (rd.free) begin
            bhdr_q.size <= bhdr_q.size + rd.size;
            u_slot_q    <= slot_of(cur_q);
            u_hdr_q     <= rd;
            ret_q       <= RET_FWD;
            state_q     <= U_START;
          end else begin
            state_q <= F_WBLK;
          end
        end
        F_WBLK: begin
          tgt_q       <= blk_q;
          p_q         <= '0;
          have_last_q <= 1'b0;
          walk_chk_q  <= 1'b0;
          state_q     <= W_RD;
        end
        F_MERGE: begin
          bhdr_q  <= '{size: last_hdr_q.size + bhdr_q.size, nxt: last_hdr_q.nxt,
                       ok: last_hdr_q.ok, free: last_hdr_q.free};
          blk_q   <= last_q;
          state_q <= F_WBLK;
        end
        F_FINAL: begin
          fh_q    <= slot_of(blk_q);
          fhv_q   <= 1'b1;
          st_q    <= ST_DONE;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        U_START: begin
          if (!fhv_q) begin
            state_q <= (ret_q == RET_FWD) ? F_FWD : F_MERGE;
          end else if (fh_q == u_slot_q) begin
            fh_q    <= u_hdr_q.nxt;
            fhv_q   <= u_hdr_q.ok;
            state_q <= (ret_q == RET_FWD) ? F_FWD : F_MERGE;
          end else begin
            up_q    <= fh_q;
            state_q <= U_RD;
          end
        end
        U_RD: state_q <= U_CHK;
        U_CHK: begin
          if (!rd.ok || rd.nxt == u_slot_q) begin
            state_q <= (ret_q == RET_FWD) ? F_FWD : F_MERGE;
          end else begin
            up_q    <= rd.nxt;
            state_q <= U_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
